// ----- src/b64d_pkg.sv -----
// b64d_pkg: shared types, codes and character classification for the base64 decoder
// used by the front end, the queue, the back end and the top level
`default_nettype none

package b64d_pkg;

    localparam int B64D_COUNT_BITS  = 16;
    localparam int B64D_QUEUE_DEPTH = 4;
    localparam int B64D_ADDR_W      = 3;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // register byte addresses, decoded by paddr[2]
    localparam logic REG_OUT_CAPACITY = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd0;
    localparam logic [2:0] ERR_MISPLACED = 3'd1;
    localparam logic [2:0] ERR_AFTER_PAD = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_PARTIAL   = 3'd4;

    // sextet markers
    localparam logic [7:0] SEX_PAD = 8'hFE;
    localparam logic [7:0] SEX_BAD = 8'hFF;

    // one queue entry: everything a single character produces
    typedef struct packed {
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
        logic            done;
        logic [15:0]     count;
        logic            err;
        logic [2:0]      code;
    } rec_t;

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            case (c) inside
                [8'h41:8'h5A]: v = c - 8'h41;
                [8'h61:8'h7A]: v = c - 8'h61 + 8'd26;
                [8'h30:8'h39]: v = c - 8'h30 + 8'd52;
                8'h2B:         v = 8'd62;
                8'h2F:         v = 8'd63;
                8'h3D:         v = SEX_PAD;
                default:       v = SEX_BAD;
            endcase
            return v;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        begin
            return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/b64d_intf.sv -----
// b64d_intf: valid/ready channel interfaces for characters in and results out
// depends on nothing
`default_nettype none

interface b64d_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, ch, last, input ready);
    modport sink (input valid, ch, last, output ready);
endinterface

interface b64d_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] byte_count;
    logic [2:0]  err_code;
    logic        run_end;

    modport source (output valid, kind, data, byte_count, err_code, run_end, input ready);
    modport sink (input valid, kind, data, byte_count, err_code, run_end, output ready);
endinterface

`default_nettype wire

// ----- src/b64d_front.sv -----
// b64d_front: takes one character per transfer, tracks group state, checks errors
// and pushes one record per character that has results; uses b64d_pkg and b64d_text_if
`default_nettype none

module b64d_front
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = B64D_COUNT_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    b64d_text_if.sink        text,
    input  wire logic [15:0] out_capacity,
    input  wire logic        q_full,
    output logic             q_push,
    output rec_t             q_rec
);

    localparam int CMP_W = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;

    logic [2:0][5:0]        held_reg, held_next;
    logic                   third_pad_reg, third_pad_next;
    logic [1:0]             fill_reg, fill_next;
    logic                   pad_seen_reg, pad_seen_next;
    logic                   failed_reg, failed_next;
    logic [COUNT_BITS-1:0]  bytes_reg, bytes_next;

    logic [7:0]             v;
    logic                   space;
    logic [1:0]             nb;
    logic [1:0]             emit_nb;
    logic [5:0]             s3;
    logic                   err_hit;
    logic [2:0]             err_c;
    logic                   done;
    logic                   clear;
    logic [COUNT_BITS:0]    total;
    logic                   overflow;
    logic [COUNT_BITS-1:0]  bytes_upd;
    logic                   accept;

    assign accept     = text.valid && text.ready;
    assign text.ready = !q_full;

    assign total    = {1'b0, bytes_reg} + (COUNT_BITS+1)'(nb);
    assign overflow = total[COUNT_BITS] || (CMP_W'(total) > CMP_W'(out_capacity));

    always_comb
    begin
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        fill_next      = fill_reg;
        pad_seen_next  = pad_seen_reg;
        failed_next    = failed_reg;
        bytes_upd      = bytes_reg;
        v              = sextet_of(text.ch);
        space          = is_space(text.ch);
        nb             = 2'd0;
        emit_nb        = 2'd0;
        s3             = 6'd0;
        err_hit        = 1'b0;
        err_c          = ERR_BAD_CHAR;
        done           = 1'b0;
        clear          = 1'b0;

        if (failed_reg)
        begin
            clear = text.last;
        end
        else
        begin
            if (!space)
            begin
                if (pad_seen_reg)
                begin
                    err_hit = 1'b1;
                    err_c   = ERR_AFTER_PAD;
                end
                else
                begin
                    case (fill_reg)
                        2'd0, 2'd1:
                        begin
                            if (v == SEX_PAD)
                            begin
                                err_hit = 1'b1;
                                err_c   = ERR_MISPLACED;
                            end
                            else if (v == SEX_BAD)
                            begin
                                err_hit = 1'b1;
                            end
                            else
                            begin
                                held_next[fill_reg] = v[5:0];
                                fill_next           = fill_reg + 2'd1;
                            end
                        end
                        2'd2:
                        begin
                            if (v == SEX_BAD)
                            begin
                                err_hit = 1'b1;
                            end
                            else
                            begin
                                third_pad_next = (v == SEX_PAD);
                                held_next[2]   = (v == SEX_PAD) ? 6'd0 : v[5:0];
                                fill_next      = 2'd3;
                            end
                        end
                        default:
                        begin
                            if (third_pad_reg)
                            begin
                                if (v != SEX_PAD)
                                begin
                                    err_hit = 1'b1;
                                    err_c   = ERR_MISPLACED;
                                end
                                else
                                begin
                                    nb = 2'd1;
                                end
                            end
                            else if (v == SEX_PAD)
                            begin
                                nb = 2'd2;
                            end
                            else if (v == SEX_BAD)
                            begin
                                err_hit = 1'b1;
                            end
                            else
                            begin
                                nb = 2'd3;
                                s3 = v[5:0];
                            end
                        end
                    endcase
                end
            end

            // group complete: capacity check, then release its bytes
            if (nb != 2'd0)
            begin
                if (overflow)
                begin
                    err_hit = 1'b1;
                    err_c   = ERR_OVERFLOW;
                end
                else
                begin
                    emit_nb        = nb;
                    bytes_upd      = total[COUNT_BITS-1:0];
                    fill_next      = 2'd0;
                    third_pad_next = 1'b0;
                    if (nb != 2'd3)
                    begin
                        pad_seen_next = 1'b1;
                    end
                end
            end

            if (!err_hit && text.last)
            begin
                if (fill_next != 2'd0)
                begin
                    err_hit = 1'b1;
                    err_c   = ERR_PARTIAL;
                end
                else
                begin
                    done = 1'b1;
                end
            end

            if (err_hit && !text.last)
            begin
                failed_next = 1'b1;
            end
            clear = text.last;
        end

        bytes_next = bytes_upd;
        if (clear)
        begin
            held_next      = '0;
            third_pad_next = 1'b0;
            fill_next      = 2'd0;
            pad_seen_next  = 1'b0;
            failed_next    = 1'b0;
            bytes_next     = '0;
        end
    end

    always_comb
    begin
        q_rec.nbytes   = emit_nb;
        q_rec.bytes[0] = {held_reg[0], held_reg[1][5:4]};
        q_rec.bytes[1] = {held_reg[1][3:0], held_reg[2][5:2]};
        q_rec.bytes[2] = {held_reg[2][1:0], s3};
        q_rec.done     = done;
        q_rec.count    = 16'(bytes_upd);
        q_rec.err      = err_hit;
        q_rec.code     = err_c;
    end

    assign q_push = accept && !failed_reg && ((emit_nb != 2'd0) || done || err_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            third_pad_reg <= 1'b0;
            fill_reg      <= 2'd0;
            pad_seen_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            bytes_reg     <= '0;
        end
        else if (accept)
        begin
            held_reg      <= held_next;
            third_pad_reg <= third_pad_next;
            fill_reg      <= fill_next;
            pad_seen_reg  <= pad_seen_next;
            failed_reg    <= failed_next;
            bytes_reg     <= bytes_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/b64d_queue.sv -----
// b64d_queue: small record fifo between the front end and the back end
// uses rec_t from b64d_pkg
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = B64D_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  rec_t      wr_rec,
    output logic      full,
    input  wire logic pop,
    output rec_t      rd_rec,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/b64d_back.sv -----
// b64d_back: unpacks each queued record into result transfers, one per cycle while the
// result channel is ready, through an output register; uses b64d_pkg and b64d_res_if
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  rec_t       q_rec,
    input  wire logic  q_empty,
    output logic       q_pop,
    b64d_res_if.source result
);

    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] count_reg;
    logic [2:0]  code_reg;
    logic        run_end_reg;

    logic [2:0]  n_items;
    logic        last_item;
    logic        load;
    logic [1:0]  kind_next;
    logic [7:0]  data_next;
    logic [15:0] count_next;
    logic [2:0]  code_next;

    assign n_items   = {1'b0, q_rec.nbytes} + {2'b0, q_rec.done} + {2'b0, q_rec.err};
    assign last_item = ({1'b0, idx_reg} + 3'd1) == n_items;
    assign load      = !q_empty && (!valid_reg || result.ready);
    assign q_pop     = load && last_item;

    // bytes first, then the done or error result
    always_comb
    begin
        kind_next  = KIND_ERR;
        data_next  = 8'd0;
        count_next = 16'd0;
        code_next  = 3'd0;
        if (idx_reg < q_rec.nbytes)
        begin
            kind_next = KIND_DATA;
            data_next = q_rec.bytes[idx_reg];
        end
        else if (q_rec.done)
        begin
            kind_next  = KIND_DONE;
            count_next = q_rec.count;
        end
        else
        begin
            code_next = q_rec.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= last_item ? 2'd0 : idx_reg + 2'd1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= kind_next;
            data_reg    <= data_next;
            count_reg   <= count_next;
            code_reg    <= code_next;
            run_end_reg <= last_item;
        end
    end

    assign result.valid      = valid_reg;
    assign result.kind       = kind_reg;
    assign result.data       = data_reg;
    assign result.byte_count = count_reg;
    assign result.err_code   = code_reg;
    assign result.run_end    = run_end_reg;

endmodule

`default_nettype wire

// ----- src/base64_decoder_strict_whitespace.sv -----
// base64 decoder top level: one character per cycle in while the queue is not full, one result
// per cycle out while the result channel is ready; a result passes through the record queue
// and the back end's output register after the transfer of the character that causes it; the
// record queue absorbs the up to four results of one character
// rst_n clears all group state, the queue and the output; out_capacity resets to 65535
// uses b64d_pkg, b64d_intf, b64d_front, b64d_queue, b64d_back
`default_nettype none

module base64_decoder_strict_whitespace
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS  = B64D_COUNT_BITS,
    parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    b64d_text_if.sink                   text,
    b64d_res_if.source                  result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [B64D_ADDR_W-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0] cap_reg;
    logic        cfg_wr;
    logic        q_full, q_empty, q_push, q_pop;
    rec_t        push_rec, head_rec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_OUT_CAPACITY))
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {16'd0, cap_reg} : 32'd0;

    b64d_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text),
        .out_capacity (cap_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_rec        (push_rec)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_rec (push_rec),
        .full   (q_full),
        .pop    (q_pop),
        .rd_rec (head_rec),
        .empty  (q_empty)
    );

    b64d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rec   (head_rec),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- src/b64d_checker.sv -----
// b64d_checker: port-level checks on the result channel of the decoder
// attached to base64_decoder_strict_whitespace by the bind below; uses b64d_pkg
`default_nettype none

module b64d_checker
    import b64d_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  res_kind,
    input wire logic [7:0]  res_data,
    input wire logic [15:0] res_count,
    input wire logic [2:0]  res_code,
    input wire logic        res_end
);

    // done and error always close the run of one character
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind != KIND_DATA) |-> res_end)
        else $error("status result without run end");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == KIND_DATA) || (res_kind == KIND_DONE) ||
                      (res_kind == KIND_ERR))
        else $error("illegal result kind");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_kind == KIND_DATA) || (res_data == 8'd0)) &&
                      ((res_kind == KIND_DONE) || (res_count == 16'd0)) &&
                      ((res_kind == KIND_ERR) || (res_code == 3'd0)))
        else $error("unused result field not zero");

    a_err_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_ERR) |-> (res_code <= ERR_PARTIAL))
        else $error("error code out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_data) &&
                                    $stable(res_count) && $stable(res_code))
        else $error("stalled result changed");

endmodule

bind base64_decoder_strict_whitespace b64d_checker u_b64d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_kind  (result.kind),
    .res_data  (result.data),
    .res_count (result.byte_count),
    .res_code  (result.err_code),
    .res_end   (result.run_end)
);

`default_nettype wire
